@@ design/gomn_pkg.sv @@
package gomn_pkg;

	localparam int COORD_W      = 6;
	localparam int DIM_W        = 6;
	localparam int CFG_IDX_W    = 2;
	localparam int MAX_SIDE_DEF = 64;
	localparam logic [DIM_W-1:0] INTERIOR_RESET = 6'd62;

	localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERIOR_H = 2'd1;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_QUERY = 2'd1,
		OP_NEIGH = 2'd2
	} op_t;

endpackage

@@ design/gomn_in_if.sv @@
interface gomn_in_if import gomn_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [COORD_W-1:0] coord_x;
	logic [COORD_W-1:0] coord_y;

	modport source (output valid, output op, output coord_x, output coord_y, input ready);
	modport sink (input valid, input op, input coord_x, input coord_y, output ready);
endinterface

@@ design/gomn_out_if.sv @@
interface gomn_out_if import gomn_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] out_x;
	logic [COORD_W-1:0] out_y;
	logic               blocked;
	logic               ok;
	logic               last;

	modport source (output valid, output out_x, output out_y, output blocked, output ok,
		output last, input ready);
	modport sink (input valid, input out_x, input out_y, input blocked, input ok,
		input last, output ready);
endinterface

@@ design/gomn_cfg_if.sv @@
interface gomn_cfg_if import gomn_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/gomn_row_ram.sv @@
module gomn_row_ram import gomn_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	localparam int AW = $clog2(MAX_SIDE)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic [MAX_SIDE-1:0] rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [MAX_SIDE-1:0] wr_data
);

	logic [MAX_SIDE-1:0] mem [MAX_SIDE];
	logic [MAX_SIDE-1:0] row_written_q;
	logic [MAX_SIDE-1:0] data_q;
	logic                hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	// a row never written reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_written_q <= '0;
			hit_q         <= 1'b0;
		end else begin
			if (wr_en) begin
				row_written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= row_written_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

@@ design/grid_obstacle_map_neighbors.sv @@
// Obstacle map of a grid of (interior_width+2) x (interior_height+2) cells, sides clamped to
// MAX_SIDE, whose outer ring always reads as blocked; coordinates off the grid read as blocked
// too. The map is held one grid row per word in a row memory with a registered read port
// and a separate write port; the block handles one request at a time. A set or a query
// runs through accept, row read, and read-modify-write or compare. A neighbor
// expansion reads the rows above, at and below the cell in turn through the one read port and
// then hands out its 1 to 4 results one per cycle while the output takes them. Each row has a
// written flag cleared by reset, so the map is clear at once after reset with no clearing
// pass. Configuration writes are taken in any cycle.
module grid_obstacle_map_neighbors import gomn_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	gomn_in_if.sink     req,
	gomn_out_if.source  rsp,
	gomn_cfg_if.sink    cfg
);

	localparam int AW = $clog2(MAX_SIDE);
	localparam int EW = ($clog2(MAX_SIDE + 1) > COORD_W + 1) ? $clog2(MAX_SIDE + 1) : COORD_W + 1;
	localparam logic [EW-1:0] SIDE = EW'(MAX_SIDE);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_ROW_D,
		ST_N_UP,
		ST_N_MID,
		ST_N_DN,
		ST_N_CAP,
		ST_EMIT
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [3:0]         mask_q;
	logic               row_in_s1;
	logic [DIM_W-1:0]   iw_q;
	logic [DIM_W-1:0]   ih_q;

	logic               out_valid_q;
	logic [COORD_W-1:0] out_x_q;
	logic [COORD_W-1:0] out_y_q;
	logic               blocked_q;
	logic               ok_q;
	logic               last_q;

	logic [EW-1:0]       gw;
	logic [EW-1:0]       gh;
	logic [EW-1:0]       ex;
	logic [EW-1:0]       ey;
	logic [EW-1:0]       rd_row;
	logic                rd_issue;
	logic                rd_en;
	logic [MAX_SIDE-1:0] rd_data;
	logic [MAX_SIDE-1:0] wr_data;
	logic                wr_en;
	logic                out_free;
	logic                out_load;
	logic                inside_xy;
	logic [1:0]          pick;
	logic [3:0]          rest;
	logic [COORD_W-1:0]  nb_x;
	logic [COORD_W-1:0]  nb_y;

	function automatic logic row_bit(input logic [MAX_SIDE-1:0] row, input logic [EW-1:0] c);
		logic b;
		b = 1'b0;
		if (c < SIDE) begin
			b = row[c[AW-1:0]];
		end
		return b;
	endfunction

	function automatic logic is_blocked(input logic [EW-1:0] cx, input logic [EW-1:0] cy,
		input logic [EW-1:0] w, input logic [EW-1:0] h, input logic mark);
		logic b;
		b = (cx >= w) || (cy >= h) || (cx == '0) || (cy == '0)
			|| (cx == w - EW'(1)) || (cy == h - EW'(1)) || mark;
		return b;
	endfunction

	always_comb begin
		logic [EW-1:0] w_raw;
		logic [EW-1:0] h_raw;
		w_raw = EW'(iw_q) + EW'(2);
		h_raw = EW'(ih_q) + EW'(2);
		gw = (w_raw > SIDE) ? SIDE : w_raw;
		gh = (h_raw > SIDE) ? SIDE : h_raw;
	end

	assign ex = EW'(x_q);
	assign ey = EW'(y_q);
	assign inside_xy = (ex < gw) && (ey < gh);

	// row address of the read issued in this state; row 0 minus one wraps far outside
	always_comb begin
		rd_row   = ey;
		rd_issue = 1'b0;
		case (state_q)
			ST_ROW, ST_N_MID: begin
				rd_row   = ey;
				rd_issue = 1'b1;
			end
			ST_N_UP: begin
				rd_row   = ey - EW'(1);
				rd_issue = 1'b1;
			end
			ST_N_DN: begin
				rd_row   = ey + EW'(1);
				rd_issue = 1'b1;
			end
			default: begin
				rd_row   = ey;
				rd_issue = 1'b0;
			end
		endcase
	end

	assign rd_en    = rd_issue && (rd_row < SIDE);
	assign out_free = !out_valid_q || rsp.ready;
	assign out_load = ((state_q == ST_ROW_D) || (state_q == ST_EMIT)) && out_free;
	assign wr_en    = (state_q == ST_ROW_D) && out_free && (op_q == OP_SET) && inside_xy;
	assign wr_data  = rd_data | (MAX_SIDE'(1) << ex);

	gomn_row_ram #(
		.MAX_SIDE(MAX_SIDE)
	) u_row_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_row[AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (ey[AW-1:0]),
		.wr_data (wr_data)
	);

	// pick the first free neighbor in up, left, right, down order
	always_comb begin
		if (mask_q[0]) begin
			pick = 2'd0;
		end else if (mask_q[1]) begin
			pick = 2'd1;
		end else if (mask_q[2]) begin
			pick = 2'd2;
		end else begin
			pick = 2'd3;
		end
		rest = mask_q & ~(4'b0001 << pick);
		case (pick)
			2'd0: begin
				nb_x = x_q;
				nb_y = y_q - COORD_W'(1);
			end
			2'd1: begin
				nb_x = x_q - COORD_W'(1);
				nb_y = y_q;
			end
			2'd2: begin
				nb_x = x_q + COORD_W'(1);
				nb_y = y_q;
			end
			default: begin
				nb_x = x_q;
				nb_y = y_q + COORD_W'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_SET;
			x_q         <= '0;
			y_q         <= '0;
			mask_q      <= '0;
			row_in_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			blocked_q   <= 1'b0;
			ok_q        <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (rd_issue) begin
				row_in_s1 <= rd_row < SIDE;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						x_q <= req.coord_x;
						y_q <= req.coord_y;
						case (req.op)
							OP_SET: begin
								op_q    <= OP_SET;
								state_q <= ST_ROW;
							end
							OP_QUERY: begin
								op_q    <= OP_QUERY;
								state_q <= ST_ROW;
							end
							OP_NEIGH: begin
								op_q    <= OP_NEIGH;
								state_q <= ST_N_UP;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ROW: state_q <= ST_ROW_D;
				ST_ROW_D: begin
					if (out_free) begin
						out_x_q     <= x_q;
						out_y_q     <= y_q;
						last_q      <= 1'b1;
						if (op_q == OP_SET) begin
							blocked_q <= 1'b0;
							ok_q      <= inside_xy;
						end else begin
							blocked_q <= is_blocked(ex, ey, gw, gh, row_bit(rd_data, ex) && row_in_s1);
							ok_q      <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_N_UP: state_q <= ST_N_MID;
				ST_N_MID: begin
					mask_q[0] <= !is_blocked(ex, ey - EW'(1), gw, gh,
						row_bit(rd_data, ex) && row_in_s1);
					state_q <= ST_N_DN;
				end
				ST_N_DN: begin
					mask_q[1] <= !is_blocked(ex - EW'(1), ey, gw, gh,
						row_bit(rd_data, ex - EW'(1)) && row_in_s1);
					mask_q[2] <= !is_blocked(ex + EW'(1), ey, gw, gh,
						row_bit(rd_data, ex + EW'(1)) && row_in_s1);
					state_q <= ST_N_CAP;
				end
				ST_N_CAP: begin
					mask_q[3] <= !is_blocked(ex, ey + EW'(1), gw, gh,
						row_bit(rd_data, ex) && row_in_s1);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						blocked_q   <= 1'b0;
						if (mask_q == '0) begin
							// no free neighbor at all
							out_x_q <= '0;
							out_y_q <= '0;
							ok_q    <= 1'b0;
							last_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							out_x_q <= nb_x;
							out_y_q <= nb_y;
							ok_q    <= 1'b1;
							last_q  <= (rest == '0);
							mask_q  <= rest;
							if (rest == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= INTERIOR_RESET;
			ih_q <= INTERIOR_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_INTERIOR_W: iw_q <= cfg.data;
				REG_INTERIOR_H: ih_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign req.ready   = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign rsp.valid   = out_valid_q;
	assign rsp.out_x   = out_x_q;
	assign rsp.out_y   = out_y_q;
	assign rsp.blocked = blocked_q;
	assign rsp.ok      = ok_q;
	assign rsp.last    = last_q;

endmodule
